FILE: rtl/llq_pkg.sv
// shared constants and types for the linked-list queue with free list
package llq_pkg;

    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_DONE  = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

endpackage

FILE: rtl/llq_ram.sv
// generic single-write, single-read memory with registered read data
module llq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/linked_list_queue_with_free_list.sv
// linked-list fifo with a free list threaded through the same link memory
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+---------------------------------
//  request  | in        | i_valid / o_ready   | i_kind, i_data_in
//  result   | out       | o_valid / i_ready   | o_data_out, o_status, o_now_empty
//
//  an item is done in two steps: a link/value memory read at the head or
//  free pointer, then a pointer update with write back of link and value.
//  after reset a sweep over all entries chains the link memory; o_ready is low.
//  a new item is accepted while the previous result still waits in the output
//  register; the update cycle stalls until that result is taken.
module linked_list_queue_with_free_list #(
    parameter int CAPACITY = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_kind,
    input  logic signed [llq_pkg::DATA_W-1:0] i_data_in,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [llq_pkg::DATA_W-1:0] o_data_out,
    output logic [llq_pkg::STATUS_W-1:0]     o_status,
    output logic                             o_now_empty
);

    // pointer width holds the null code CAPACITY
    localparam int IW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [IW-1:0] NIL = IW'(CAPACITY);
    localparam logic [IW-1:0] LAST = IW'(CAPACITY - 1);

    localparam logic [1:0] S_INIT = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0]                 r_state, n_state;
    logic [IW-1:0]              r_init_idx;
    logic [IW-1:0]              r_head, n_head;
    logic [IW-1:0]              r_tail, n_tail;
    logic [IW-1:0]              r_free, n_free;
    logic                       r_kind;
    logic [llq_pkg::DATA_W-1:0] r_data;

    logic                       r_o_valid;
    logic [llq_pkg::DATA_W-1:0] r_data_out, n_data_out;
    llq_pkg::t_status           r_status, n_status;
    logic                       r_now_empty, n_now_empty;

    logic                       w_accept;
    logic                       w_fire;
    logic                       w_enq_ok;
    logic                       w_deq_ok;

    // link memory ports
    logic                       w_link_we;
    logic [AW-1:0]              w_link_waddr;
    logic [IW-1:0]              w_link_wdata;
    logic [AW-1:0]              w_link_raddr;
    logic [IW-1:0]              w_link_rdata;
    logic                       w_val_we;
    logic [llq_pkg::DATA_W-1:0] w_val_rdata;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_fire   = (r_state == S_EXEC) && (!r_o_valid || i_ready);
    assign w_enq_ok = (r_kind == llq_pkg::KIND_ENQ) && (r_free != NIL);
    assign w_deq_ok = (r_kind == llq_pkg::KIND_DEQ) && (r_head != NIL);

    // dequeue follows the head link, enqueue follows the free link
    assign w_link_raddr = (i_kind == llq_pkg::KIND_DEQ) ? r_head[AW-1:0] : r_free[AW-1:0];

    always_comb begin
        w_link_we    = 1'b0;
        w_link_waddr = r_init_idx[AW-1:0];
        w_link_wdata = r_init_idx + IW'(1);
        w_val_we     = 1'b0;
        if (r_state == S_INIT) begin
            w_link_we = 1'b1;
        end else if (w_fire && w_enq_ok) begin
            w_val_we     = 1'b1;
            // append after the tail only when the queue already holds nodes
            w_link_we    = (r_head != NIL);
            w_link_waddr = r_tail[AW-1:0];
            w_link_wdata = r_free;
        end else if (w_fire && w_deq_ok) begin
            // freed node goes to the front of the free list
            w_link_we    = 1'b1;
            w_link_waddr = r_head[AW-1:0];
            w_link_wdata = r_free;
        end
    end

    llq_ram #(
        .WIDTH(IW),
        .DEPTH(CAPACITY)
    ) u_link_ram (
        .i_clk  (i_clk),
        .i_we   (w_link_we),
        .i_waddr(w_link_waddr),
        .i_wdata(w_link_wdata),
        .i_re   (w_accept),
        .i_raddr(w_link_raddr),
        .o_rdata(w_link_rdata)
    );

    llq_ram #(
        .WIDTH(llq_pkg::DATA_W),
        .DEPTH(CAPACITY)
    ) u_value_ram (
        .i_clk  (i_clk),
        .i_we   (w_val_we),
        .i_waddr(r_free[AW-1:0]),
        .i_wdata(r_data),
        .i_re   (w_accept),
        .i_raddr(r_head[AW-1:0]),
        .o_rdata(w_val_rdata)
    );

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_free      = r_free;
        n_data_out  = '0;
        n_status    = llq_pkg::ST_DONE;
        n_now_empty = (r_head == NIL);
        if (r_kind == llq_pkg::KIND_ENQ) begin
            if (w_enq_ok) begin
                n_free = w_link_rdata;
                n_tail = r_free;
                if (r_head == NIL) begin
                    n_head = r_free;
                end
                n_now_empty = 1'b0;
            end else begin
                n_status = llq_pkg::ST_FULL;
            end
        end else begin
            if (w_deq_ok) begin
                n_data_out = w_val_rdata;
                n_free     = r_head;
                // last node leaves: its link is not kept, so compare with tail
                if (r_head == r_tail) begin
                    n_head      = NIL;
                    n_tail      = NIL;
                    n_now_empty = 1'b1;
                end else begin
                    n_head      = w_link_rdata;
                    n_now_empty = 1'b0;
                end
            end else begin
                n_status = llq_pkg::ST_EMPTY;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (r_init_idx == LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_init_idx <= '0;
            r_head     <= NIL;
            r_tail     <= NIL;
            r_free     <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_INIT) begin
                r_init_idx <= r_init_idx + IW'(1);
            end
            if (w_fire) begin
                r_head    <= n_head;
                r_tail    <= n_tail;
                r_free    <= n_free;
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_kind;
            r_data <= $unsigned(i_data_in);
        end
        if (w_fire) begin
            r_data_out  <= n_data_out;
            r_status    <= n_status;
            r_now_empty <= n_now_empty;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_data_out  = $signed(r_data_out);
    assign o_status    = r_status;
    assign o_now_empty = r_now_empty;

    // head and tail are null together
    a_head_tail_nil: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == NIL) == (r_tail == NIL))
        else $error("head and tail disagree on empty queue");

    // a finished update always presents a result
    a_fire_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> o_valid)
        else $error("update without result");

    // dequeued node becomes the free-list head
    a_deq_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_deq_ok) |=> (r_free == $past(r_head)) && (o_status == llq_pkg::ST_DONE))
        else $error("dequeued node not returned to free list");

    // enqueued node becomes the tail and the queue is not empty
    a_enq_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_enq_ok) |=> (r_tail == $past(r_free)) && !o_now_empty)
        else $error("enqueued node not linked at tail");

    // no accept while the link memory is being chained
    a_no_accept_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !o_ready)
        else $error("item accepted during link sweep");

endmodule
